>>> sv/ecrm_pkg.sv
// Shared types and constants for the fader smoothing and range-map block.
// Used by the interfaces, the state memory, the divider and the top level.
package ecrm_pkg;

    localparam int CH_W     = 3;
    localparam int SMOOTH_W = 16;
    localparam int BETA_W   = 17;
    localparam int RANGE_W  = 12;
    localparam int OUT_W    = 12;
    localparam int IDX_W    = 2;

    // The shifted limit can grow by up to eight bits before it saturates.
    localparam int LIM_WIDE_W = RANGE_W + 8;

    // Fraction bits of the smoothing factor.
    localparam int FRAC_W = 16;

    // Map product: smoothed value times the magnitude of the output span.
    localparam int MAP_PROD_W = SMOOTH_W + OUT_W;

    // The mapped quotient never exceeds the span, so it has OUT_W bits.
    localparam int DIV_STEPS = OUT_W;
    localparam int DIV_CNT_W = 4;

    localparam logic [BETA_W-1:0]   BETA_RESET  = 17'd65536;
    localparam logic [RANGE_W-1:0]  RANGE_RESET = 12'd4095;
    localparam logic [OUT_W-1:0]    LOW_RESET   = 12'd0;
    localparam logic [OUT_W-1:0]    HIGH_RESET  = 12'd4095;
    localparam logic [SMOOTH_W-1:0] SMOOTH_MAX  = 16'hFFFF;

    typedef enum logic [IDX_W-1:0] {
        REG_BETA     = 2'd0,
        REG_RANGE    = 2'd1,
        REG_OUT_LOW  = 2'd2,
        REG_OUT_HIGH = 2'd3
    } reg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_UPDATE,
        S_SCALE,
        S_DIV,
        S_DONE
    } state_t;

endpackage

>>> sv/ecrm_if.sv
// Handshake channels of the smoothing block: sample beats in, result beats out.
// Depends on ecrm_pkg for the field widths.
interface ecrm_in_if;
    logic                         valid;
    logic                         ready;
    logic [ecrm_pkg::CH_W-1:0]     channel;
    logic [ecrm_pkg::SMOOTH_W-1:0] raw_sample;

    modport source (output valid, output channel, output raw_sample, input ready);
    modport sink   (input valid, input channel, input raw_sample, output ready);
endinterface

interface ecrm_out_if;
    logic                         valid;
    logic                         ready;
    logic [ecrm_pkg::CH_W-1:0]     channel_out;
    logic [ecrm_pkg::SMOOTH_W-1:0] smoothed;
    logic [ecrm_pkg::OUT_W-1:0]    mapped;

    modport source (output valid, output channel_out, output smoothed, output mapped,
                    input ready);
    modport sink   (input valid, input channel_out, input smoothed, input mapped,
                    output ready);
endinterface

>>> sv/ecrm_smooth_mem.sv
// Per-channel smoothed-value store: one synchronous read port, one write port.
// Valid bits make never-written entries read as zero after reset. Uses ecrm_pkg.
module ecrm_smooth_mem #(
    parameter int DEPTH  = 8,
    parameter int ADDR_W = 3
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          rd_en,
    input  logic [ADDR_W-1:0]             rd_addr,
    output logic [ecrm_pkg::SMOOTH_W-1:0] rd_data,
    input  logic                          wr_en,
    input  logic [ADDR_W-1:0]             wr_addr,
    input  logic [ecrm_pkg::SMOOTH_W-1:0] wr_data
);

    logic [ecrm_pkg::SMOOTH_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]              written_reg;
    logic [ecrm_pkg::SMOOTH_W-1:0] rd_word_reg;
    logic                          rd_hit_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_word_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
            rd_hit_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                written_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_hit_reg <= written_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_hit_reg ? rd_word_reg : '0;

endmodule

>>> sv/ecrm_divider.sv
// Restoring divider, one quotient bit per cycle, for the linear range map.
// The caller guarantees the quotient fits in OUT_W bits. Uses ecrm_pkg.
module ecrm_divider (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [ecrm_pkg::MAP_PROD_W-1:0] dividend,
    input  logic [ecrm_pkg::SMOOTH_W-1:0]   divisor,
    output logic                            done,
    output logic [ecrm_pkg::OUT_W-1:0]      quotient
);

    logic                            busy_reg;
    logic [ecrm_pkg::DIV_CNT_W-1:0]  cnt_reg;
    logic [ecrm_pkg::SMOOTH_W-1:0]   rem_reg;
    logic [ecrm_pkg::SMOOTH_W-1:0]   rem_next;
    logic [ecrm_pkg::OUT_W-1:0]      dq_reg;
    logic [ecrm_pkg::OUT_W-1:0]      dq_next;
    logic [ecrm_pkg::SMOOTH_W-1:0]   div_reg;
    logic [ecrm_pkg::SMOOTH_W:0]     trial;
    logic                            fits;

    // The dividend's low bits shift in one at a time while quotient bits
    // fill the same register from the bottom.
    assign trial = {rem_reg, dq_reg[ecrm_pkg::OUT_W-1]};
    assign fits  = (trial >= {1'b0, div_reg});

    always_comb
    begin
        rem_next = fits ? ecrm_pkg::SMOOTH_W'(trial - {1'b0, div_reg})
                        : trial[ecrm_pkg::SMOOTH_W-1:0];
        dq_next  = {dq_reg[ecrm_pkg::OUT_W-2:0], fits};
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend[ecrm_pkg::MAP_PROD_W-1:ecrm_pkg::OUT_W];
            dq_reg  <= dividend[ecrm_pkg::OUT_W-1:0];
            div_reg <= divisor;
        end
        else if (busy_reg && (cnt_reg != '0))
        begin
            rem_reg <= rem_next;
            dq_reg  <= dq_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= ecrm_pkg::DIV_CNT_W'(ecrm_pkg::DIV_STEPS);
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    assign done     = busy_reg && (cnt_reg == '0);
    assign quotient = dq_reg;

endmodule

>>> sv/ema_clamp_range_map_unit.sv
// Fader smoothing unit. Each sample beat updates one channel's exponential
// moving average, held in a small synchronous memory, and returns the new
// clamped value with its linear map onto out_low..out_high. One item is in
// flight at a time: the next sample is taken only after the item has passed
// the read, update and scale steps and the one-bit-per-cycle divider of the
// range map (12 quotient steps); with a zero axis range the divider is skipped.
// A finished result sits in an output register, so a new sample is accepted
// while that result waits. The user must write configuration only while no
// item is in flight; the block itself does not enforce this.
module ema_clamp_range_map_unit #(
    parameter int CHANNELS     = 8,
    parameter int SAMPLE_SHIFT = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic [ecrm_pkg::IDX_W-1:0]    wr_index,
    input  logic [ecrm_pkg::BETA_W-1:0]   wr_data,
    ecrm_in_if.sink                       samples,
    ecrm_out_if.source                    results
);

    localparam int ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    ecrm_pkg::state_t state_reg, state_next;

    logic [ecrm_pkg::BETA_W-1:0]  beta_reg;
    logic [ecrm_pkg::RANGE_W-1:0] range_reg;
    logic [ecrm_pkg::OUT_W-1:0]   low_reg;
    logic [ecrm_pkg::OUT_W-1:0]   high_reg;

    logic [ecrm_pkg::CH_W-1:0]     ch_reg;
    logic [ADDR_W-1:0]             addr_reg;
    logic                          ch_ok_reg;
    logic [ecrm_pkg::SMOOTH_W-1:0] raw_reg;
    logic [ecrm_pkg::SMOOTH_W-1:0] prev_reg;
    logic signed [34:0]            prod_reg;
    logic [ecrm_pkg::SMOOTH_W-1:0] sm_reg;
    logic                          neg_reg;
    logic [ecrm_pkg::OUT_W-1:0]    mapped_reg;
    logic [ecrm_pkg::OUT_W-1:0]    mapped_next;

    logic                          out_valid_reg;
    logic [ecrm_pkg::CH_W-1:0]     out_ch_reg;
    logic [ecrm_pkg::SMOOTH_W-1:0] out_sm_reg;
    logic [ecrm_pkg::OUT_W-1:0]    out_map_reg;

    logic                          accept;
    logic                          in_ch_ok;
    logic                          mem_rd_en;
    logic                          mem_we;
    logic                          out_load;
    logic [ecrm_pkg::SMOOTH_W-1:0] mem_rd_data;
    logic                          div_start;
    logic                          div_done;
    logic [ecrm_pkg::OUT_W-1:0]    div_quot;

    logic [ecrm_pkg::LIM_WIDE_W-1:0] lim_wide;
    logic [ecrm_pkg::SMOOTH_W-1:0]   lim;
    logic [ecrm_pkg::SMOOTH_W-1:0]   raw_clamped;
    logic [ecrm_pkg::SMOOTH_W-1:0]   prev;
    logic signed [16:0]              err;
    logic signed [34:0]              prod_next;
    logic signed [34:0]              prod_biased;
    logic signed [18:0]              refl;
    logic signed [19:0]              ema_next;
    logic [ecrm_pkg::SMOOTH_W-1:0]   sm_next;
    logic signed [12:0]              span;
    logic [ecrm_pkg::OUT_W-1:0]      span_mag;
    logic [ecrm_pkg::MAP_PROD_W-1:0] map_prod;
    logic signed [12:0]              map_sum;

    // Full-scale limit, saturated to the sample width.
    assign lim_wide = ecrm_pkg::LIM_WIDE_W'(range_reg) << SAMPLE_SHIFT;
    assign lim      = (lim_wide > ecrm_pkg::LIM_WIDE_W'(ecrm_pkg::SMOOTH_MAX))
                      ? ecrm_pkg::SMOOTH_MAX : lim_wide[ecrm_pkg::SMOOTH_W-1:0];

    assign accept      = samples.valid && samples.ready;
    assign in_ch_ok    = (32'(samples.channel) < CHANNELS);
    assign raw_clamped = (samples.raw_sample >= lim) ? lim : samples.raw_sample;

    // Update arithmetic.
    always_comb
    begin
        prev        = ch_ok_reg ? mem_rd_data : '0;
        err         = $signed({1'b0, prev}) - $signed({1'b0, raw_reg});
        prod_next   = 35'(err) * 35'($signed({1'b0, beta_reg}));
        // Bias negative products so the shift truncates toward zero.
        prod_biased = prod_reg + (prod_reg[34] ? 35'sd65535 : 35'sd0);
        refl        = 19'(prod_biased >>> ecrm_pkg::FRAC_W);
        ema_next    = $signed({4'b0, prev_reg}) - 20'(refl);
        if (ema_next[19])
        begin
            sm_next = '0;
        end
        else if (ema_next >= $signed({4'b0, lim}))
        begin
            sm_next = lim;
        end
        else
        begin
            sm_next = ema_next[ecrm_pkg::SMOOTH_W-1:0];
        end
    end

    // Range-map arithmetic.
    always_comb
    begin
        span     = $signed({1'b0, high_reg}) - $signed({1'b0, low_reg});
        span_mag = span[12] ? ecrm_pkg::OUT_W'(-span) : span[ecrm_pkg::OUT_W-1:0];
        map_prod = ecrm_pkg::MAP_PROD_W'(sm_reg) * ecrm_pkg::MAP_PROD_W'(span_mag);
        map_sum  = neg_reg ? ($signed({1'b0, low_reg}) - $signed({1'b0, div_quot}))
                           : ($signed({1'b0, low_reg}) + $signed({1'b0, div_quot}));
        if (state_reg == ecrm_pkg::S_SCALE)
        begin
            mapped_next = low_reg;
        end
        else
        begin
            mapped_next = map_sum[ecrm_pkg::OUT_W-1:0];
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ecrm_pkg::S_IDLE:
            begin
                if (samples.valid)
                begin
                    state_next = ecrm_pkg::S_READ;
                end
            end
            ecrm_pkg::S_READ:   state_next = ecrm_pkg::S_UPDATE;
            ecrm_pkg::S_UPDATE: state_next = ecrm_pkg::S_SCALE;
            ecrm_pkg::S_SCALE:
            begin
                state_next = (lim == '0) ? ecrm_pkg::S_DONE : ecrm_pkg::S_DIV;
            end
            ecrm_pkg::S_DIV:
            begin
                if (div_done)
                begin
                    state_next = ecrm_pkg::S_DONE;
                end
            end
            ecrm_pkg::S_DONE:
            begin
                if (!out_valid_reg || results.ready)
                begin
                    state_next = ecrm_pkg::S_IDLE;
                end
            end
            default: state_next = ecrm_pkg::S_IDLE;
        endcase
    end

    // State outputs.
    always_comb
    begin
        samples.ready = 1'b0;
        mem_rd_en     = 1'b0;
        mem_we        = 1'b0;
        div_start     = 1'b0;
        out_load      = 1'b0;
        unique case (state_reg)
            ecrm_pkg::S_IDLE:
            begin
                samples.ready = 1'b1;
                mem_rd_en     = samples.valid && in_ch_ok;
            end
            ecrm_pkg::S_READ:   ;
            ecrm_pkg::S_UPDATE: mem_we = ch_ok_reg;
            ecrm_pkg::S_SCALE:  div_start = (lim != '0);
            ecrm_pkg::S_DIV:    ;
            ecrm_pkg::S_DONE:   out_load = !out_valid_reg || results.ready;
            default:            ;
        endcase
    end

    // The new value is written back in the same cycle it is registered.
    ecrm_smooth_mem #(
        .DEPTH  (CHANNELS),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (mem_rd_en),
        .rd_addr (ADDR_W'(samples.channel)),
        .rd_data (mem_rd_data),
        .wr_en   (mem_we),
        .wr_addr (addr_reg),
        .wr_data (sm_next)
    );

    ecrm_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (map_prod),
        .divisor  (lim),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Control state and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ecrm_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
            beta_reg      <= ecrm_pkg::BETA_RESET;
            range_reg     <= ecrm_pkg::RANGE_RESET;
            low_reg       <= ecrm_pkg::LOW_RESET;
            high_reg      <= ecrm_pkg::HIGH_RESET;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (wr_en)
            begin
                unique case (ecrm_pkg::reg_idx_t'(wr_index))
                    ecrm_pkg::REG_BETA:     beta_reg  <= wr_data;
                    ecrm_pkg::REG_RANGE:    range_reg <= wr_data[ecrm_pkg::RANGE_W-1:0];
                    ecrm_pkg::REG_OUT_LOW:  low_reg   <= wr_data[ecrm_pkg::OUT_W-1:0];
                    ecrm_pkg::REG_OUT_HIGH: high_reg  <= wr_data[ecrm_pkg::OUT_W-1:0];
                    default:                ;
                endcase
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ch_reg    <= samples.channel;
            addr_reg  <= ADDR_W'(samples.channel);
            ch_ok_reg <= in_ch_ok;
            raw_reg   <= raw_clamped;
        end
        if (state_reg == ecrm_pkg::S_READ)
        begin
            prev_reg <= prev;
            prod_reg <= prod_next;
        end
        if (state_reg == ecrm_pkg::S_UPDATE)
        begin
            sm_reg <= sm_next;
        end
        if (state_reg == ecrm_pkg::S_SCALE)
        begin
            neg_reg <= span[12];
        end
        if (((state_reg == ecrm_pkg::S_SCALE) && (lim == '0)) || div_done)
        begin
            mapped_reg <= mapped_next;
        end
        if (out_load)
        begin
            out_ch_reg  <= ch_reg;
            out_sm_reg  <= sm_reg;
            out_map_reg <= mapped_reg;
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.channel_out = out_ch_reg;
    assign results.smoothed    = out_sm_reg;
    assign results.mapped      = out_map_reg;

`ifndef SYNTHESIS
    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ecrm_pkg::S_DIV))
        else $error("divider finished outside the divide state");

    a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ecrm_pkg::S_READ))
        else $error("accepted beat did not start a memory read");

    a_write_in_update: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> ((state_reg == ecrm_pkg::S_UPDATE) && ch_ok_reg))
        else $error("state memory written outside the update step");

    a_smoothed_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> (results.smoothed <= lim))
        else $error("smoothed result above the full-scale limit");
`endif

endmodule
